@@ sv/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime test block.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // The first divisor that the search tries.
  localparam int unsigned FirstDivisor = 2;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_e;

endpackage

@@ sv/trial_division_prime_test_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Reports whether an unsigned candidate is prime by trial division.
// ----------------------------------------------------------------------------
// Usage: the caller places a candidate on candidate_i and raises start. The
// item is taken at a rising edge where start is high and busy is low. For a
// candidate of two or more, busy then stays high until the answer is ready.
// The answer appears on is_prime_o for exactly one cycle, marked by done_o.
// The receiver cannot hold it off, so it must capture the item in that cycle.
//
// Search: candidates 0 and 1 answer in the cycle after being taken. Otherwise
// every trial divisor costs a square bound check and a one-bit-per-cycle
// restoring remainder over all candidate bits. Up to about 256 divisors are
// tried for a 16-bit candidate, each through the shared remainder unit.
// A new item may be taken in the same cycle its predecessor's answer shows.
//
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// done_o; any search in progress is abandoned without an answer.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output logic                 done_o,
  output logic                 is_prime_o
);

  // The squared divisor can pass the candidate by about 2*sqrt(n)+1 before
  // the loop stops, so it carries two extra bits.
  localparam int unsigned SqW  = NUM_WIDTH + 2;
  localparam int unsigned CntW = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  state_e               state_q, state_d;
  logic [NUM_WIDTH-1:0] cand_q, cand_d;
  logic [NUM_WIDTH-1:0] div_q, div_d;
  logic [SqW-1:0]       sq_q, sq_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [CntW-1:0]      bit_q, bit_d;
  logic                 done_q, done_d;
  logic                 prime_q, prime_d;

  // Shared remainder unit: one restoring step per cycle.
  logic [NUM_WIDTH:0]   trial_rem;
  logic [NUM_WIDTH:0]   div_ext;
  logic                 fits;
  logic [NUM_WIDTH-1:0] step_rem;

  assign trial_rem = {rem_q, cand_q[bit_q]};
  assign div_ext   = {1'b0, div_q};
  assign fits      = (trial_rem >= div_ext);
  assign step_rem  = fits ? NUM_WIDTH'(trial_rem - div_ext) : NUM_WIDTH'(trial_rem);

  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cand_d = candidate_i;
          div_d  = NUM_WIDTH'(FirstDivisor);
          sq_d   = SqW'(FirstDivisor * FirstDivisor);
          if (candidate_i < NUM_WIDTH'(FirstDivisor)) begin
            // Zero and one are not prime; no divisor is tried.
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > {2'b00, cand_q}) begin
          // No divisor up to the square root: the candidate is prime.
          done_d  = 1'b1;
          prime_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rem_d   = '0;
          bit_d   = CntW'(NUM_WIDTH - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = step_rem;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          if (step_rem == '0) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + SqW'({div_q, 1'b1});
            div_d   = div_q + 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    prime_q <= prime_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule

@@ sv/tdpt_checker.sv @@
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks of the prime test's command and answer timing.
// ----------------------------------------------------------------------------
module tdpt_checker #(
  parameter int unsigned NUM_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [NUM_WIDTH-1:0] candidate_i,
  input logic                 done_o,
  input logic                 is_prime_o
);

  // An answer is never shown while a search is still running.
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done_o high while busy");

  // Every finished search delivers its answer as busy drops.
  a_fall_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without an answer");

  // Zero and one are answered next cycle as not prime.
  a_small : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (candidate_i == '0 || candidate_i == NUM_WIDTH'(1)))
      |=> (done_o && !is_prime_o && !busy))
    else $error("zero or one not answered as not prime");

  // A larger candidate starts a search.
  a_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && candidate_i > NUM_WIDTH'(1)) |=> (busy && !done_o))
    else $error("search did not start");

endmodule

bind trial_division_prime_test_top tdpt_checker #(
  .NUM_WIDTH(NUM_WIDTH)
) u_tdpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .candidate_i(candidate_i),
  .done_o     (done_o),
  .is_prime_o (is_prime_o)
);
